@@ rtl/bbdf_pkg.sv @@
// package for the blocked bloom dedup filter
// constants, register index and sequencer states; no dependencies
package bbdf_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int BLOCKS_W       = 13;
  localparam int PADDR_W        = 3;
  localparam int WORDS_PER_BLK  = 8;

  localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 13'd4096;

  localparam logic [63:0] H1_SEED   = 64'hcbf29ce484222325;
  localparam logic [63:0] H2_SEED   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] H1_MUL    = 64'h00000100000001b3;
  localparam logic [63:0] H2_ADD    = 64'h000000009e3779b9;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

  // register indexes
  localparam logic REG_BLOCKS = 1'b0;

  localparam logic [5:0] LAST_KEY_BYTE = 6'd33;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ABS_A,
    S_ABS_B,
    S_FIN1,
    S_FIN2,
    S_DIV,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

@@ rtl/bbdf_key_if.sv @@
// key channel: valid/ready handshake with the 34-byte position key
// no dependencies
interface bbdf_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] board_word_0;
  logic [63:0] board_word_1;
  logic [63:0] board_word_2;
  logic [63:0] board_word_3;
  logic [15:0] position_aux;

  modport source (output valid, board_word_0, board_word_1, board_word_2, board_word_3,
                  position_aux, input ready);
  modport sink (input valid, board_word_0, board_word_1, board_word_2, board_word_3,
                position_aux, output ready);
endinterface

@@ rtl/bbdf_result_if.sv @@
// result channel: valid/ready handshake with the seen_before flag
// no dependencies
interface bbdf_result_if;
  logic valid;
  logic ready;
  logic seen_before;

  modport source (output valid, seen_before, input ready);
  modport sink (input valid, seen_before, output ready);
endinterface

@@ rtl/bbdf_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bbdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/blocked_bloom_dedup_filter.sv @@
// blocked bloom filter for duplicate detection of position keys
// depends on bbdf_pkg, bbdf_key_if, bbdf_result_if and bbdf_ram
//
// On the way from a key beat's acceptance to its result beat, every 64-bit
// product goes through a single shared 32x32 multiplier in three passes (68
// products while absorbing the 34 key bytes, four in the finalizers), the block
// index comes from a remainder unit that handles one dividend bit a cycle, and
// the eight filter words are read and rewritten through the ram's one read and
// one write port. Only one key is in flight; the result sits in an output
// register so the next key is taken while it waits. After reset the filter
// store is cleared one word a cycle, during which no key is taken; the register
// port works throughout. blocks_in_use of zero acts as one, above NUM_BLOCKS it
// saturates.
module blocked_bloom_dedup_filter #(
  parameter int NUM_BLOCKS = bbdf_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbdf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  bbdf_key_if.sink                   key,
  bbdf_result_if.source              result
);
  import bbdf_pkg::*;

  localparam int DEPTH  = NUM_BLOCKS * WORDS_PER_BLK;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state, state_next;

  // config register
  logic [BLOCKS_W-1:0] blocks_in_use;
  logic [BLOCKS_W-1:0] n_eff;

  // hash datapath
  logic [271:0] key_bytes;
  logic [5:0]   byte_cnt;
  logic [63:0]  ha, hb;
  logic [63:0]  mul_a, mul_b, acc, mul_sum;
  logic [31:0]  mul_x, mul_y;
  logic [63:0]  prod;
  logic [1:0]   phase;
  logic         mul_done;
  logic         fin_sel;
  logic [7:0]   cur_byte, nxt_byte;

  // remainder unit
  logic [BLOCKS_W-1:0] rem;
  logic [BLOCKS_W:0]   rem_sh, rem_sub;
  logic [5:0]          div_cnt;

  // probe
  logic [3:0]        probe_cnt;
  logic              present;
  logic              rd_bit;
  logic [31:0]       rd_full, wr_full;
  logic [ADDR_W-1:0] clr_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [63:0]       ram_wdata, ram_rdata;

  // output register
  logic out_valid, out_seen;
  logic out_load;

  // ---------------- register port ----------------
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BLOCKS) begin
      prdata = {{(32-BLOCKS_W){1'b0}}, blocks_in_use};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BLOCKS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLOCKS) begin
      blocks_in_use <= pwdata[BLOCKS_W-1:0];
    end
  end

  // effective divisor: zero acts as one, saturate at the store size
  always_comb begin
    if (blocks_in_use == '0) begin
      n_eff = BLOCKS_W'(1);
    end else if ({19'd0, blocks_in_use} > NUM_BLOCKS) begin
      n_eff = BLOCKS_W'(NUM_BLOCKS);
    end else begin
      n_eff = blocks_in_use;
    end
  end

  // ---------------- shared multiplier ----------------
  // three passes build the low 64 bits of mul_a * mul_b
  always_comb begin
    case (phase)
      2'd0: begin
        mul_x = mul_a[31:0];
        mul_y = mul_b[31:0];
      end
      2'd1: begin
        mul_x = mul_a[31:0];
        mul_y = mul_b[63:32];
      end
      default: begin
        mul_x = mul_a[63:32];
        mul_y = mul_b[31:0];
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign mul_sum  = (phase == 2'd0) ? prod : acc + {prod[31:0], 32'd0};
  assign mul_done = (phase == 2'd2);

  always_comb begin
    case (state)
      S_ABS_A: mul_b = H1_MUL;
      S_FIN2:  mul_b = MIX_MUL_B;
      default: mul_b = MIX_MUL_A;
    endcase
  end

  assign cur_byte = key_bytes[7:0];
  assign nxt_byte = key_bytes[15:8];

  // ---------------- remainder step ----------------
  assign rem_sh  = {rem, ha[63]};
  assign rem_sub = rem_sh - {1'b0, n_eff};

  // ---------------- filter store ----------------
  assign rd_full = {{(32-BLOCKS_W-3){1'b0}}, rem, probe_cnt[2:0]};
  assign wr_full = {{(32-BLOCKS_W-3){1'b0}}, rem, 3'(probe_cnt - 4'd1)};
  assign rd_bit  = ram_rdata[hb[5:0]];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_full[ADDR_W-1:0];
    ram_wdata = ram_rdata | (64'd1 << hb[5:0]);
    ram_raddr = rd_full[ADDR_W-1:0];
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_PROBE && probe_cnt != 4'd0) begin
      ram_we = 1'b1;
    end
  end

  bbdf_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  assign key.ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (key.valid) state_next = S_ABS_A;
      end
      S_ABS_A: begin
        if (mul_done) state_next = S_ABS_B;
      end
      S_ABS_B: begin
        if (mul_done) state_next = (byte_cnt == LAST_KEY_BYTE) ? S_FIN1 : S_ABS_A;
      end
      S_FIN1: begin
        if (mul_done) state_next = S_FIN2;
      end
      S_FIN2: begin
        if (mul_done) state_next = fin_sel ? S_DIV : S_FIN1;
      end
      S_DIV: begin
        if (div_cnt == 6'd63) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (probe_cnt == 4'd8) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (state == S_ABS_A || state == S_ABS_B || state == S_FIN1 || state == S_FIN2) begin
        phase <= mul_done ? 2'd0 : phase + 2'd1;
      end else begin
        phase <= 2'd0;
      end
      if (result.valid && result.ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc <= mul_sum;
    case (state)
      S_IDLE: begin
        key_bytes <= {key.position_aux, key.board_word_3, key.board_word_2,
                      key.board_word_1, key.board_word_0};
        byte_cnt  <= '0;
        ha        <= H1_SEED;
        hb        <= H2_SEED;
        mul_a     <= H1_SEED ^ {56'd0, key.board_word_0[7:0]};
        fin_sel   <= 1'b0;
      end
      S_ABS_A: begin
        if (mul_done) begin
          ha    <= mul_sum;
          mul_a <= hb ^ ({56'd0, cur_byte} + H2_ADD);
        end
      end
      S_ABS_B: begin
        if (mul_done) begin
          hb        <= mul_sum;
          key_bytes <= key_bytes >> 8;
          byte_cnt  <= byte_cnt + 6'd1;
          if (byte_cnt == LAST_KEY_BYTE) begin
            mul_a <= ha ^ (ha >> 30);
          end else begin
            mul_a <= ha ^ {56'd0, nxt_byte};
          end
        end
      end
      S_FIN1: begin
        if (mul_done) mul_a <= mul_sum ^ (mul_sum >> 27);
      end
      S_FIN2: begin
        if (mul_done) begin
          if (!fin_sel) begin
            ha      <= mul_sum ^ (mul_sum >> 31);
            mul_a   <= hb ^ (hb >> 30);
            fin_sel <= 1'b1;
          end else begin
            hb <= mul_sum ^ (mul_sum >> 31);
          end
          rem     <= '0;
          div_cnt <= '0;
        end
      end
      S_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem       <= (rem_sh >= {1'b0, n_eff}) ? rem_sub[BLOCKS_W-1:0] : rem_sh[BLOCKS_W-1:0];
        ha        <= ha << 1;
        div_cnt   <= div_cnt + 6'd1;
        probe_cnt <= '0;
        present   <= 1'b1;
      end
      S_PROBE: begin
        // read word k while checking and rewriting word k-1
        probe_cnt <= probe_cnt + 4'd1;
        if (probe_cnt != 4'd0) begin
          present <= present & rd_bit;
          hb      <= hb >> 8;
        end
      end
      default: begin
      end
    endcase
    if (out_load) out_seen <= present;
  end

  assign result.valid       = out_valid;
  assign result.seen_before = out_seen;

  // ---------------- assertions ----------------
  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase != 2'd3)
    else $error("multiplier phase out of range");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < n_eff)
    else $error("remainder not below divisor");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside done state");

  a_no_key_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !(key.valid && key.ready) || state != S_CLEAR)
    else $error("key taken during clearing pass");

endmodule
